// ===== hdl/xsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsf_pkg: shared types and constants for the XOR sprite frame buffer
// Screen geometry, request and result payload types, sequencer states.
// ----------------------------------------------------------------------------
package xsf_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int SPRITE_WIDTH  = 8;

  localparam int COL_W     = $clog2(SCREEN_WIDTH);
  localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
  localparam int ROW_SUM_W = $clog2(SCREEN_HEIGHT + 16);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef struct packed {
    action_t                   action;
    logic [7:0]                x_coord;
    logic [7:0]                y_coord;
    logic [3:0]                row_index;
    logic [SPRITE_WIDTH-1:0]   row_bits;
    logic                      last_row;
  } in_t;

  typedef struct packed {
    logic collision;
    logic pixel;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_t;

endpackage

// ===== hdl/xor_sprite_framebuffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer: monochrome frame buffer with XOR sprite drawing
// Clear, draw-sprite-row and read-pixel requests on one row memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request (clear, draw row, read pixel).
//   out_valid/out_ready/out_data return exactly one result per request.
//   Each request is one pass over the row memory: the row is read and, for a
//   draw on screen, masked with the shifted sprite bits by a single XOR unit
//   and written back. The row is read in ST_READ and the result registered
//   when ST_MODIFY ends; no new request is taken until ST_IDLE returns. The
//   row memory serves one row read, then at most one row write, per request.
//   Clear passes through the same states: per-row valid bits are dropped at once.
//   Reset (rst_n low, synchronous) empties the screen and the collision flag
//   with no clearing pass. If the receiver stalls, the finished result
//   holds in the output register; the next request is still accepted and
//   completes once that register is free.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  xsf_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output xsf_pkg::out_t out_data
);

  localparam int W   = xsf_pkg::SCREEN_WIDTH;
  localparam int H   = xsf_pkg::SCREEN_HEIGHT;
  localparam int SW  = xsf_pkg::SPRITE_WIDTH;
  localparam int CW  = xsf_pkg::COL_W;
  localparam int RW  = xsf_pkg::ROW_W;
  localparam int RSW = xsf_pkg::ROW_SUM_W;

  xsf_pkg::state_t state_r, state_nxt;
  xsf_pkg::in_t    item_r;
  logic [RSW-1:0]  row_r, row_nxt;
  logic [W-1:0]    mem [H];
  logic [W-1:0]    rdata_r;
  logic            rvld_r;
  logic [H-1:0]    valid_r;
  logic            sticky_r, sticky_nxt;
  xsf_pkg::out_t   out_r, res;
  logic            out_valid_r;

  logic            accept;
  logic            commit;
  logic            mem_we;
  logic            clr_all;
  logic [W-1:0]    old_row;
  logic [SW-1:0]   rev_bits;
  logic [W+SW-1:0] mask_wide;
  logic [W-1:0]    mask;
  logic            in_range;
  logic            hit;
  logic [CW-1:0]   sx;

  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xsf_pkg::ST_IDLE:   if (accept) state_nxt = xsf_pkg::ST_READ;
      xsf_pkg::ST_READ:   state_nxt = xsf_pkg::ST_MODIFY;
      xsf_pkg::ST_MODIFY: if (!out_valid_r || out_ready) state_nxt = xsf_pkg::ST_IDLE;
      default:            state_nxt = xsf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state_r)
      xsf_pkg::ST_IDLE:   in_ready = 1'b1;
      xsf_pkg::ST_READ:   ;
      xsf_pkg::ST_MODIFY: commit = !out_valid_r || out_ready;
      default:            ;
    endcase
  end

  // row address: start row wraps, offset may run past the bottom
  always_comb begin
    if (in_data.action == xsf_pkg::ACT_DRAW) begin
      row_nxt = RSW'(in_data.y_coord[RW-1:0]) + RSW'(in_data.row_index);
    end else begin
      row_nxt = RSW'(in_data.y_coord[RW-1:0]);
    end
  end

  // shared XOR / shift unit
  always_comb begin
    for (int i = 0; i < SW; i++) begin
      rev_bits[i] = item_r.row_bits[SW-1-i];
    end
    sx        = item_r.x_coord[CW-1:0];
    old_row   = rvld_r ? rdata_r : '0;
    mask_wide = (W+SW)'(rev_bits) << sx;
    mask      = mask_wide[W-1:0];
    in_range  = row_r < RSW'(H);
    hit       = in_range && |(old_row & mask);
  end

  always_comb begin
    res        = '0;
    sticky_nxt = sticky_r;
    mem_we     = 1'b0;
    clr_all    = 1'b0;
    case (item_r.action)
      xsf_pkg::ACT_CLEAR: clr_all = commit;
      xsf_pkg::ACT_DRAW: begin
        res.collision = sticky_r | hit;
        sticky_nxt    = item_r.last_row ? 1'b0 : res.collision;
        mem_we        = commit && in_range;
      end
      xsf_pkg::ACT_READ:  res.pixel = old_row[sx];
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xsf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sticky_r    <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        sticky_r    <= sticky_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (clr_all) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[row_r[RW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      row_r  <= row_nxt;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  // row memory: one read in ST_READ, one write at commit of an in-range draw
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row_r[RW-1:0]] <= old_row ^ mask;
    end
    if (state_r == xsf_pkg::ST_READ) begin
      rdata_r <= mem[row_r[RW-1:0]];
      rvld_r  <= valid_r[row_r[RW-1:0]];
    end
  end

endmodule

// ===== hdl/xsf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsf_checker: port-level checks for the XOR sprite frame buffer
// Watches both channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module xsf_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input xsf_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input xsf_pkg::out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a result never appears the cycle after a request is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // a result is either a collision report or a pixel, not both
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.collision && out_data.pixel))
    else $error("collision and pixel both set");

endmodule

bind xor_sprite_framebuffer xsf_checker u_xsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/xor_sprite_framebuffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_tb: self-checking bench for the XOR sprite buffer
// Directed clear/draw/read requests at the screen edges, then random sprites
// drawn and erased with pixel reads around them. A behavioral copy of the
// screen predicts every result; the sender works in bursts and the receiver
// stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer_tb;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         RAND_ITEMS  = 950;
  localparam int         CYCLE_LIMIT = 400000;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  xsf_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  xsf_pkg::out_t out_data;

  logic [xsf_pkg::SCREEN_WIDTH-1:0] lit_rows [xsf_pkg::SCREEN_HEIGHT];
  logic                    sticky_hit;
  xsf_pkg::out_t           flags_due [$];
  int                      bad_results = 0;
  int                      items_sent  = 0;
  int                      burst_left  = 0;
  int                      cycle_count = 0;
  logic [7:0]              rx_phase    = '0;

  xor_sprite_framebuffer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[xor_sprite_framebuffer] ERROR");
      $finish;
    end
  end

  // receiver: always ready, 1-in-4 stalls, coin flips, long stalls
  always @(posedge clk) begin
    rx_phase <= rx_phase + 8'd1;
    case (rx_phase[7:6])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= (rx_phase[1:0] != 2'd3);
      2'd2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_phase[3:0] >= 4'd12);
    endcase
  end

  function automatic xsf_pkg::out_t apply_to_frame(xsf_pkg::in_t req);
    xsf_pkg::out_t res;
    int   sx;
    int   sy;
    int   row;
    int   col;
    logic hit;
    res = '0;
    hit = 1'b0;
    sx  = req.x_coord % xsf_pkg::SCREEN_WIDTH;
    sy  = req.y_coord % xsf_pkg::SCREEN_HEIGHT;
    case (req.action)
      xsf_pkg::ACT_CLEAR: begin
        foreach (lit_rows[r]) lit_rows[r] = '0;
      end
      xsf_pkg::ACT_DRAW: begin
        row = sy + req.row_index;
        if (row < xsf_pkg::SCREEN_HEIGHT) begin
          for (int i = 0; i < xsf_pkg::SPRITE_WIDTH; i++) begin
            col = sx + i;
            if (col < xsf_pkg::SCREEN_WIDTH &&
                req.row_bits[xsf_pkg::SPRITE_WIDTH-1-i]) begin
              if (lit_rows[row][col]) hit = 1'b1;
              lit_rows[row][col] = ~lit_rows[row][col];
            end
          end
        end
        res.collision = sticky_hit | hit;
        sticky_hit    = req.last_row ? 1'b0 : res.collision;
      end
      xsf_pkg::ACT_READ: begin
        res.pixel = lit_rows[sy][sx];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    xsf_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (flags_due.size() == 0) begin
        if (bad_results < 10)
          $display("%0t: result with no request pending: collision=%b pixel=%b",
                   $realtime, out_data.collision, out_data.pixel);
        bad_results++;
      end else begin
        want = flags_due.pop_front();
        if (want.collision !== out_data.collision || want.pixel !== out_data.pixel) begin
          if (bad_results < 10)
            $display("%0t: expected collision=%b pixel=%b, got collision=%b pixel=%b",
                     $realtime, want.collision, want.pixel,
                     out_data.collision, out_data.pixel);
          bad_results++;
        end
      end
    end
  end

  function automatic xsf_pkg::in_t make_req(logic [1:0] act, logic [7:0] x, logic [7:0] y,
                                            logic [3:0] ridx, logic [7:0] bits, logic last);
    xsf_pkg::in_t req;
    req.action    = xsf_pkg::action_t'(act);
    req.x_coord   = x;
    req.y_coord   = y;
    req.row_index = ridx;
    req.row_bits  = bits;
    req.last_row  = last;
    return req;
  endfunction

  task automatic send_req(input xsf_pkg::in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    flags_due.push_back(apply_to_frame(req));
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // hold off until the block has returned everything in flight
  task automatic settle_frame();
    in_valid <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_readback();
    send_req(make_req(xsf_pkg::ACT_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send_req(make_req(xsf_pkg::ACT_READ, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1));
  endtask

  task automatic test_draw_edges();
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b0));
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd0, 8'd0, 4'd1, 8'h81, 1'b1));
    send_req(make_req(xsf_pkg::ACT_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send_req(make_req(xsf_pkg::ACT_READ, 8'd7, 8'd1, 4'd0, 8'h00, 1'b0));
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd0, 8'd0, 4'd0, 8'h80, 1'b0));
    // rows below the bottom edge: no change, flag still carried and cleared
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd0, 8'd31, 4'd1, 8'hFF, 1'b0));
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd0, 8'd31, 4'd15, 8'hFF, 1'b1));
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd60, 8'd5, 4'd0, 8'hFF, 1'b1));
    send_req(make_req(xsf_pkg::ACT_READ, 8'd63, 8'd5, 4'd0, 8'h00, 1'b0));
    send_req(make_req(xsf_pkg::ACT_READ, 8'd124, 8'd37, 4'd0, 8'h00, 1'b0));
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd252, 8'd37, 4'd0, 8'h0F, 1'b1));
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd124, 8'd5, 4'd0, 8'hF0, 1'b1));
  endtask

  task automatic test_clear_keeps_flag();
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd0, 8'd0, 4'd0, 8'h01, 1'b0));
    send_req(make_req(xsf_pkg::ACT_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send_req(make_req(xsf_pkg::ACT_DRAW, 8'd0, 8'd0, 4'd0, 8'h00, 1'b1));
    send_req(make_req(xsf_pkg::ACT_READ, 8'd7, 8'd0, 4'd0, 8'h00, 1'b0));
  endtask

  task automatic test_unused_action();
    send_req(make_req(ACT_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send_req(make_req(xsf_pkg::ACT_READ, 8'd60, 8'd5, 4'd0, 8'h00, 1'b0));
  endtask

  task automatic test_random_sprites();
    logic [7:0] rows [16];
    logic [7:0] sx;
    logic [7:0] sy;
    int         n;
    int         pick;
    int         passes;
    int         stop_at;
    sx      = '0;
    sy      = '0;
    n       = 1;
    stop_at = items_sent + RAND_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        sx = $urandom_range(0, 3) == 0 ? 8'(sx + $urandom_range(0, 7))
                                       : 8'($urandom_range(0, 255));
        sy = $urandom_range(0, 3) == 0 ? 8'(sy + $urandom_range(0, 7))
                                       : 8'($urandom_range(0, 255));
        n  = $urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) rows[i] = 8'($urandom_range(0, 255));
        passes = $urandom_range(0, 9) < 4 ? 2 : 1;
        repeat (passes) begin
          for (int i = 0; i < n; i++)
            send_req(make_req(xsf_pkg::ACT_DRAW, sx, sy, 4'(i), rows[i], i == n - 1));
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6))
          send_req(make_req(xsf_pkg::ACT_READ, sx + 8'($urandom_range(0, 9)),
                            sy + 8'($urandom_range(0, n)), 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end else if (pick < 84) begin
        send_req(make_req(xsf_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1))));
      end else if (pick < 88) begin
        send_req(make_req(ACT_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1))));
      end else if (pick < 97) begin
        // stray row: arbitrary offset and end marker
        send_req(make_req(xsf_pkg::ACT_DRAW, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1))));
      end else begin
        settle_frame();
      end
    end
  endtask

  initial begin
    foreach (lit_rows[r]) lit_rows[r] = '0;
    sticky_hit = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_readback();
    settle_frame();
    test_draw_edges();
    settle_frame();
    test_clear_keeps_flag();
    settle_frame();
    test_unused_action();
    test_random_sprites();

    settle_frame();
    repeat (10) @(posedge clk);
    if (bad_results == 0 && flags_due.size() == 0) begin
      $display("[xor_sprite_framebuffer] OK");
    end else begin
      $display("[xor_sprite_framebuffer] ERROR");
    end
    $finish;
  end

endmodule
